[hw/rtl/nfp_pkg.sv]
// Shared types, field widths and codes for the NOR flash model with power cut.
package nfp_pkg;

	localparam int FLASH_BYTES_DEF = 4096;

	localparam int REQ_W       = 2;
	localparam int START_W     = 12;
	localparam int LEN_W       = 13;
	localparam int IDX_W       = 12;
	localparam int DATA_W      = 8;
	localparam int STATUS_W    = 2;
	localparam int CUT_W       = 13;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 8;

	localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

	typedef enum logic [REQ_W-1:0] {
		REQ_READ    = 2'd0,
		REQ_PROGRAM = 2'd1,
		REQ_ERASE   = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_OOB    = 2'd1,
		STAT_POWER  = 2'd2,
		STAT_HALTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RDATA,
		S_PROG,
		S_WALK
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

[hw/rtl/nfp_array.sv]
// Byte-wide flash array: single-port synchronous memory with a registered read.
module nfp_array #(
	parameter int DEPTH = nfp_pkg::FLASH_BYTES_DEF
) (
	input  logic                       clk,
	input  nfp_pkg::mem_ctl_t          ctl,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  logic [nfp_pkg::DATA_W-1:0] wdata,
	output logic [nfp_pkg::DATA_W-1:0] rdata
);
	import nfp_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/nfp_ctrl.sv]
// Request sequencer: decode, bounds and power-cut checks, read-modify-write and erase walk.
module nfp_ctrl #(
	parameter int FLASH_BYTES = nfp_pkg::FLASH_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [nfp_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic [nfp_pkg::REQ_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [nfp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic [nfp_pkg::STATUS_W-1:0]      m_tuser,
	input  logic signed [nfp_pkg::CUT_W-1:0]  cut_addr,
	output nfp_pkg::mem_ctl_t                 mem_ctl,
	output logic [$clog2(FLASH_BYTES)-1:0]    mem_addr,
	output logic [nfp_pkg::DATA_W-1:0]        mem_wdata,
	input  logic [nfp_pkg::DATA_W-1:0]        mem_rdata
);
	import nfp_pkg::*;

	localparam int AW    = $clog2(FLASH_BYTES);
	localparam int CNT_W = AW + 1;
	localparam int SUM_W = 14;
	localparam int EXT_W = (AW > SUM_W) ? AW : SUM_W;
	localparam logic [31:0] FLASH_SIZE = 32'(FLASH_BYTES);

	state_t             state_q, state_d;
	logic               halted_q, halted_d;
	logic [AW-1:0]      ptr_q, ptr_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [AW-1:0]      addr_q, addr_d;
	logic [DATA_W-1:0]  pdata_q, pdata_d;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q, load_data;
	status_t            out_status_q, load_status;
	logic               out_load;
	logic               accept;

	req_t               req;
	logic [START_W-1:0] start;
	logic [LEN_W-1:0]   len;
	logic [IDX_W-1:0]   idx;
	logic [DATA_W-1:0]  data;
	logic [SUM_W-1:0]   bound_sum;
	logic [LEN_W-1:0]   byte_addr;
	logic [EXT_W-1:0]   byte_ext;
	logic [EXT_W-1:0]   start_ext;
	logic               oob;
	logic               idx_out;
	logic               addr_out;
	logic               cut_hit;

	assign req   = req_t'(s_tuser);
	assign start = s_tdata[11:0];
	assign len   = s_tdata[24:12];
	assign idx   = s_tdata[36:25];
	assign data  = s_tdata[44:37];

	assign bound_sum = {2'b00, start} + {1'b0, len};
	assign byte_addr = {1'b0, start} + {1'b0, idx};
	assign byte_ext  = EXT_W'(byte_addr);
	assign start_ext = EXT_W'(start);
	assign oob       = 32'(bound_sum) > FLASH_SIZE;
	assign idx_out   = {1'b0, idx} >= len;
	assign addr_out  = 32'(byte_addr) >= FLASH_SIZE;
	assign cut_hit   = !cut_addr[CUT_W-1] && ($unsigned(cut_addr) == byte_addr);

	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d     = state_q;
		halted_d    = halted_q;
		ptr_d       = ptr_q;
		cnt_d       = cnt_q;
		addr_d      = addr_q;
		pdata_d     = pdata_q;
		out_load    = 1'b0;
		load_data   = '0;
		load_status = STAT_OK;
		mem_ctl     = '0;
		mem_addr    = ptr_q;
		mem_wdata   = ERASED_BYTE;
		case (state_q)
			S_CLEAR, S_WALK: begin
				mem_ctl.wr_en = 1'b1;
				ptr_d = ptr_q + AW'(1);
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					out_load = 1'b1;
					if (halted_q) begin
						load_status = STAT_HALTED;
					end else begin
						case (req)
							REQ_READ, REQ_PROGRAM: begin
								if (oob) begin
									halted_d    = 1'b1;
									load_status = STAT_OOB;
								end else if (idx_out || addr_out) begin
									load_status = STAT_OK;
								end else if (req == REQ_READ) begin
									out_load      = 1'b0;
									mem_ctl.rd_en = 1'b1;
									mem_addr      = byte_ext[AW-1:0];
									state_d       = S_RDATA;
								end else if (cut_hit) begin
									halted_d    = 1'b1;
									load_status = STAT_POWER;
								end else begin
									mem_ctl.rd_en = 1'b1;
									mem_addr      = byte_ext[AW-1:0];
									addr_d        = byte_ext[AW-1:0];
									pdata_d       = data;
									state_d       = S_PROG;
								end
							end
							REQ_ERASE: begin
								if (oob) begin
									halted_d    = 1'b1;
									load_status = STAT_OOB;
								end else if (len != '0) begin
									ptr_d   = start_ext[AW-1:0];
									cnt_d   = CNT_W'(len);
									state_d = S_WALK;
								end
							end
							default: begin
								load_status = STAT_OK;
							end
						endcase
					end
				end
			end
			S_RDATA: begin
				out_load    = 1'b1;
				load_data   = mem_rdata;
				load_status = STAT_OK;
				state_d     = S_IDLE;
			end
			S_PROG: begin
				mem_ctl.wr_en = 1'b1;
				mem_addr      = addr_q;
				mem_wdata     = mem_rdata & pdata_q;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			halted_q    <= 1'b0;
			ptr_q       <= '0;
			cnt_q       <= CNT_W'(FLASH_BYTES);
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			halted_q <= halted_d;
			ptr_q    <= ptr_d;
			cnt_q    <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_d;
		pdata_q <= pdata_d;
		if (out_load) begin
			out_data_q   <= load_data;
			out_status_q <= load_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_load && out_valid_q && !m_tready))
		else $error("Result register loaded while an earlier result is still pending.");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("Halted flag cleared without a reset.");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDATA) |=> out_valid_q)
		else $error("Read data phase did not produce a result.");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.wr_en && mem_ctl.rd_en))
		else $error("Memory read and write issued in the same cycle.");

	a_no_prog_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> (state_q != S_PROG))
		else $error("Program write attempted while halted.");

endmodule

[hw/rtl/nor_flash_model_with_power_cut.sv]
// Top level of the NOR flash array model with a configurable power-cut address.
//
// Channel   Direction  Transaction                      Payload
// s_*       in         one read/program byte or erase   tuser: req_type; tdata: access fields
// m_*       out        one result per request           tuser: status; tdata: read_data
// cfg_*     in         write of power_cut_addr          cfg_wdata: 13-bit two's complement
//
// After reset the array is filled with 0xFF and no request is accepted until the fill ends. A read
// or program byte issues the array read in the request cycle, and in the next cycle the byte is
// returned or the cleared bits are written back through the single array port. An erase then
// writes 0xFF to each byte of its range in turn; any other request is done in its request cycle.
// A request is taken only when the result register is free or being drained.
module nor_flash_model_with_power_cut #(
	parameter int FLASH_BYTES = nfp_pkg::FLASH_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// start_addr[11:0], access_length[24:12], byte_index[36:25], data_byte[44:37], zero fill
	input  logic [nfp_pkg::IN_TDATA_W-1:0]    s_tdata,
	// req_type[1:0]
	input  logic [nfp_pkg::REQ_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_data[7:0]
	output logic [nfp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// status[1:0]
	output logic [nfp_pkg::STATUS_W-1:0]      m_tuser,
	input  logic                              cfg_we,
	input  logic [nfp_pkg::CUT_W-1:0]         cfg_wdata
);
	import nfp_pkg::*;

	localparam int AW = $clog2(FLASH_BYTES);

	logic signed [CUT_W-1:0] cut_addr_q;
	mem_ctl_t                mem_ctl;
	logic [AW-1:0]           mem_addr;
	logic [DATA_W-1:0]       mem_wdata;
	logic [DATA_W-1:0]       mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_addr_q <= '1;
		end else if (cfg_we) begin
			cut_addr_q <= $signed(cfg_wdata);
		end
	end

	nfp_ctrl #(
		.FLASH_BYTES(FLASH_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cut_addr  (cut_addr_q),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	nfp_array #(
		.DEPTH(FLASH_BYTES)
	) u_array (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule
